### rtl/nsr_pkg.sv
// Shared types and constants for the Newton square root block.
// No dependencies; compiled first.
`timescale 1ns / 1ps
`default_nettype none

package nsr_pkg;

  localparam int RADICAND_W = 32;
  localparam int ROOT_W     = 25;
  localparam int STEPS_W    = 7;
  localparam int TOL_W      = 16;
  localparam int CFG_DATA_W = 16;

  localparam logic [ROOT_W-1:0]  ROOT_MAX     = {ROOT_W{1'b1}};
  localparam logic [STEPS_W-1:0] STEP_CAP     = 7'd64;
  localparam logic [TOL_W-1:0]   TOL_RESET    = 16'd1;
  localparam logic [STEPS_W-1:0] MAX_IT_RESET = 7'd32;

  // register indexes on the configuration port
  typedef enum logic [0:0] {
    CFG_TOLERANCE = 1'b0,
    CFG_MAX_ITER  = 1'b1
  } cfg_idx_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_LAUNCH,
    ST_DIV,
    ST_STEP,
    ST_CHECK,
    ST_OUT
  } state_t;

  typedef struct packed {
    logic [RADICAND_W-1:0] radicand;
  } in_item_t;

  typedef struct packed {
    logic [ROOT_W-1:0]  root;
    logic               converged;
    logic [STEPS_W-1:0] steps_taken;
  } out_item_t;

  // divider status back to the sequencer
  typedef struct packed {
    logic busy;
    logic done;
  } div_stat_t;

endpackage

`default_nettype wire

### rtl/nsr_chan_if.sv
// Valid/ready channel interface carrying one item payload.
// Payload type is a parameter; used with nsr_pkg item structs.
`timescale 1ns / 1ps
`default_nettype none

interface nsr_chan_if #(
  parameter type payload_t = logic
);
  logic     valid;
  logic     ready;
  payload_t data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

`default_nettype wire

### rtl/nsr_div.sv
// Shared restoring divider: floor((x << FRAC_BITS) / d), one quotient bit per cycle.
// Depends on nsr_pkg for the status struct.
`timescale 1ns / 1ps
`default_nettype none

module nsr_div #(
  parameter int FRAC_BITS  = 16,
  parameter int DATA_WIDTH = 32
) (
  input  wire                               clk,
  input  wire                               rst_n,
  input  wire                               start,
  input  wire  [DATA_WIDTH-1:0]             dividend,
  input  wire  [DATA_WIDTH-1:0]             divisor,
  output nsr_pkg::div_stat_t                stat,
  output logic [DATA_WIDTH+FRAC_BITS-1:0]   quotient
);

  localparam int QW  = DATA_WIDTH + FRAC_BITS;
  localparam int CNW = $clog2(QW + 1);

  logic [QW-1:0]         quo_r;
  logic [DATA_WIDTH-1:0] rem_r;
  logic [DATA_WIDTH-1:0] dv_r;
  logic [CNW-1:0]        cnt_r;
  logic                  busy_r;
  logic                  done_r;

  logic [DATA_WIDTH:0]   rem_sh;
  logic [DATA_WIDTH:0]   rem_sub;
  logic                  q_bit;

  // shift in the next dividend bit, trial subtract
  assign rem_sh  = {rem_r, quo_r[QW-1]};
  assign rem_sub = rem_sh - {1'b0, dv_r};
  assign q_bit   = (rem_sh >= {1'b0, dv_r});

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        busy_r <= 1'b1;
        cnt_r  <= CNW'(QW);
      end else if (busy_r) begin
        cnt_r <= cnt_r - 1'b1;
        if (cnt_r == CNW'(1)) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      quo_r <= {dividend, FRAC_BITS'(0)};
      rem_r <= '0;
      // zero divisor acts as one
      dv_r  <= (divisor == '0) ? DATA_WIDTH'(1) : divisor;
    end else if (busy_r) begin
      quo_r <= {quo_r[QW-2:0], q_bit};
      rem_r <= q_bit ? rem_sub[DATA_WIDTH-1:0] : rem_sh[DATA_WIDTH-1:0];
    end
  end

  assign stat.busy = busy_r;
  assign stat.done = done_r;
  assign quotient  = quo_r;

endmodule

`default_nettype wire

### rtl/newton_square_root.sv
// Newton square root top level: sequencer around the shared divider.
// Depends on nsr_pkg, nsr_chan_if and nsr_div.
`timescale 1ns / 1ps
`default_nettype none

// Square root of an unsigned fixed-point radicand (Q16.16 by default) by Newton
// (Heron) iteration. The estimate starts at 1.0 and each step forms
// new = (old + floor((x << FRAC_BITS) / old)) >> 1, truncating. It stops when
// two estimates differ by at most `tolerance` LSBs (converged = 1) or after
// `max_iterations` steps (converged = 0; a limit of 0 runs one step, above 64
// runs 64). Roots wider than 25 bits saturate to all ones. One item in, one
// item out; the block holds in_if.ready low while it works on an item. Each
// Newton step runs one division on the one-bit-per-cycle restoring divider
// that every step shares; a zero radicand skips the divider. A finished
// item sits in an output register, so the next item may be accepted while it
// waits to be taken. Configuration: index 0 tolerance (16 bits, reset 1),
// index 1 max_iterations (7 bits, reset 32); the user must write them only
// while idle, as the block itself does not enforce it.
module newton_square_root #(
  parameter int FRAC_BITS  = 16,
  parameter int DATA_WIDTH = 32
) (
  input  wire                               clk,
  input  wire                               rst_n,
  nsr_chan_if.sink                          in_if,
  nsr_chan_if.source                        out_if,
  input  wire                               cfg_wr_en,
  input  wire  [0:0]                        cfg_index,
  input  wire  [nsr_pkg::CFG_DATA_W-1:0]    cfg_wr_data
);

  localparam int QW = DATA_WIDTH + FRAC_BITS;
  localparam int SW = QW + 1;

  // config registers
  logic [nsr_pkg::TOL_W-1:0]   tol_r;
  logic [nsr_pkg::STEPS_W-1:0] max_it_r;

  // sequencer state
  nsr_pkg::state_t state_r, state_nxt;

  logic [DATA_WIDTH-1:0]       x_r;
  logic [DATA_WIDTH-1:0]       old_r;
  logic [DATA_WIDTH-1:0]       new_r;
  logic [nsr_pkg::STEPS_W-1:0] step_r;
  logic [nsr_pkg::STEPS_W-1:0] lim_r;
  logic                        conv_r;

  nsr_pkg::out_item_t          out_r;
  logic                        out_valid_r;

  // datapath
  logic                        in_acc;
  logic [DATA_WIDTH-1:0]       x_in;
  logic [nsr_pkg::STEPS_W-1:0] lim_in;
  logic                        div_start;
  nsr_pkg::div_stat_t          div_stat;
  logic [QW-1:0]               quo;
  logic [SW-1:0]               sum;
  logic [DATA_WIDTH-1:0]       est_sat;
  logic [DATA_WIDTH-1:0]       diff;
  logic                        tol_ok;
  logic                        at_limit;
  logic                        out_load;
  logic [nsr_pkg::ROOT_W-1:0]  root_sat;

  assign in_acc = in_if.valid && in_if.ready;
  assign x_in   = DATA_WIDTH'(in_if.data.radicand);

  // clamp iteration limit to 1..64
  always_comb begin
    if (max_it_r == '0) begin
      lim_in = nsr_pkg::STEPS_W'(1);
    end else if (max_it_r > nsr_pkg::STEP_CAP) begin
      lim_in = nsr_pkg::STEP_CAP;
    end else begin
      lim_in = max_it_r;
    end
  end

  nsr_div #(
    .FRAC_BITS  (FRAC_BITS),
    .DATA_WIDTH (DATA_WIDTH)
  ) u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (div_start),
    .dividend (x_r),
    .divisor  (old_r),
    .stat     (div_stat),
    .quotient (quo)
  );

  // (old >> 1) + (q >> 1) + carry of the two low bits, held to DATA_WIDTH bits
  assign sum = SW'(old_r >> 1) + SW'(quo >> 1) + SW'(old_r[0] & quo[0]);
  assign est_sat = (sum[SW-1:DATA_WIDTH] != '0) ? {DATA_WIDTH{1'b1}}
                                                 : sum[DATA_WIDTH-1:0];

  assign diff     = (old_r > new_r) ? (old_r - new_r) : (new_r - old_r);
  assign tol_ok   = (diff <= DATA_WIDTH'(tol_r));
  assign at_limit = (step_r >= lim_r);

  assign root_sat = (new_r > DATA_WIDTH'(nsr_pkg::ROOT_MAX)) ? nsr_pkg::ROOT_MAX
                                                             : nsr_pkg::ROOT_W'(new_r);

  assign out_load = (state_r == nsr_pkg::ST_OUT) && (!out_valid_r || out_if.ready);

  // next state and control
  always_comb begin
    state_nxt = state_r;
    div_start = 1'b0;
    case (state_r)
      nsr_pkg::ST_IDLE: begin
        if (in_if.valid) begin
          state_nxt = (x_in == '0) ? nsr_pkg::ST_OUT : nsr_pkg::ST_LAUNCH;
        end
      end
      nsr_pkg::ST_LAUNCH: begin
        div_start = 1'b1;
        state_nxt = nsr_pkg::ST_DIV;
      end
      nsr_pkg::ST_DIV: begin
        if (div_stat.done) begin
          state_nxt = nsr_pkg::ST_STEP;
        end
      end
      nsr_pkg::ST_STEP: begin
        state_nxt = nsr_pkg::ST_CHECK;
      end
      nsr_pkg::ST_CHECK: begin
        state_nxt = (tol_ok || at_limit) ? nsr_pkg::ST_OUT : nsr_pkg::ST_LAUNCH;
      end
      nsr_pkg::ST_OUT: begin
        if (out_load) begin
          state_nxt = nsr_pkg::ST_IDLE;
        end
      end
      default: begin
        state_nxt = nsr_pkg::ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= nsr_pkg::ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  // config writes
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      tol_r    <= nsr_pkg::TOL_RESET;
      max_it_r <= nsr_pkg::MAX_IT_RESET;
    end else if (cfg_wr_en) begin
      case (cfg_index)
        nsr_pkg::CFG_TOLERANCE: tol_r    <= cfg_wr_data;
        nsr_pkg::CFG_MAX_ITER:  max_it_r <= cfg_wr_data[nsr_pkg::STEPS_W-1:0];
        default: begin
        end
      endcase
    end
  end

  // iteration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      step_r <= '0;
      conv_r <= 1'b0;
    end else begin
      if (in_acc) begin
        x_r    <= x_in;
        lim_r  <= lim_in;
        old_r  <= DATA_WIDTH'(1) << FRAC_BITS;
        new_r  <= '0;
        step_r <= '0;
        conv_r <= (x_in == '0);
      end else if (state_r == nsr_pkg::ST_STEP) begin
        new_r  <= est_sat;
        step_r <= step_r + 1'b1;
      end else if (state_r == nsr_pkg::ST_CHECK) begin
        conv_r <= tol_ok;
        if (!tol_ok && !at_limit) begin
          old_r <= new_r;
        end
      end
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (out_load) begin
      out_valid_r <= 1'b1;
    end else if (out_if.ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      out_r.root        <= root_sat;
      out_r.converged   <= conv_r;
      out_r.steps_taken <= step_r;
    end
  end

  assign in_if.ready  = (state_r == nsr_pkg::ST_IDLE);
  assign out_if.valid = out_valid_r;
  assign out_if.data  = out_r;

`ifndef SYNTHESIS
  a_div_start_idle: assert property (@(posedge clk) disable iff (!rst_n)
    div_start |-> !div_stat.busy)
    else $error("divider started while busy");

  a_check_steps: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == nsr_pkg::ST_CHECK) |-> (step_r != '0 && step_r <= lim_r))
    else $error("step count out of range at check");

  a_out_steps_cap: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> (out_r.steps_taken <= nsr_pkg::STEP_CAP))
    else $error("result step count above cap");

  a_fail_has_steps: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && !out_r.converged) |-> (out_r.steps_taken != '0))
    else $error("unconverged result with no steps");

  a_div_done_in_wait: assert property (@(posedge clk) disable iff (!rst_n)
    div_stat.done |-> (state_r == nsr_pkg::ST_DIV))
    else $error("divider finished outside wait state");
`endif

endmodule

`default_nettype wire
